// ===== hdl/ble_pkg.sv =====
// Shared types and constants for the battery level estimator.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

	// field widths
	localparam int RAW_W    = 12;
	localparam int SAMPLE_W = 13;
	localparam int THR_W    = 13;
	localparam int FO_W     = 8;
	localparam int CAL_W    = 11;
	localparam int LEVEL_W  = 3;
	localparam int EMPTY_W  = 3;

	// level quantizer: thresholds above the register set are never exceeded
	localparam int NUM_THR  = 4;
	localparam int LEVELS   = 4;
	localparam int LVL_USED = (LEVELS < NUM_THR) ? LEVELS : NUM_THR;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// empty counter
	localparam logic [EMPTY_W-1:0] EMPTY_SAT  = 3'd5;
	localparam logic [EMPTY_W-1:0] EMPTY_MARK = 3'd4;

	// register reset values
	localparam logic [THR_W-1:0] THR1_RST = 13'd660;
	localparam logic [THR_W-1:0] THR2_RST = 13'd690;
	localparam logic [THR_W-1:0] THR3_RST = 13'd699;
	localparam logic [THR_W-1:0] THR4_RST = 13'd707;
	localparam logic [FO_W-1:0]  FO_RST   = 8'd23;

	// register map, word index into the APB space
	typedef enum logic [2:0] {
		REG_THR1  = 3'd0,
		REG_THR2  = 3'd1,
		REG_THR3  = 3'd2,
		REG_THR4  = 3'd3,
		REG_FO_EN = 3'd4,
		REG_FO    = 3'd5,
		REG_CAL   = 3'd6
	} reg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [NUM_THR-1:0][THR_W-1:0] thr;
		logic                          fo_en;
		logic [FO_W-1:0]               fo;
		logic signed [CAL_W-1:0]       cal;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/ble_cfg.sv =====
// APB register file holding thresholds and sample correction settings.
`timescale 1ns / 1ps
`default_nettype none

module ble_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready,
	output      ble_pkg::cfg_t       cfg
);

	ble_pkg::cfg_t     cfg_q;
	ble_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = ble_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr[0] <= ble_pkg::THR1_RST;
			cfg_q.thr[1] <= ble_pkg::THR2_RST;
			cfg_q.thr[2] <= ble_pkg::THR3_RST;
			cfg_q.thr[3] <= ble_pkg::THR4_RST;
			cfg_q.fo_en  <= 1'b1;
			cfg_q.fo     <= ble_pkg::FO_RST;
			cfg_q.cal    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				ble_pkg::REG_THR1:  cfg_q.thr[0] <= pwdata[ble_pkg::THR_W-1:0];
				ble_pkg::REG_THR2:  cfg_q.thr[1] <= pwdata[ble_pkg::THR_W-1:0];
				ble_pkg::REG_THR3:  cfg_q.thr[2] <= pwdata[ble_pkg::THR_W-1:0];
				ble_pkg::REG_THR4:  cfg_q.thr[3] <= pwdata[ble_pkg::THR_W-1:0];
				ble_pkg::REG_FO_EN: cfg_q.fo_en  <= pwdata[0];
				ble_pkg::REG_FO:    cfg_q.fo     <= pwdata[ble_pkg::FO_W-1:0];
				ble_pkg::REG_CAL:   cfg_q.cal    <= signed'(pwdata[ble_pkg::CAL_W-1:0]);
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			ble_pkg::REG_THR1:  prdata = 32'(cfg_q.thr[0]);
			ble_pkg::REG_THR2:  prdata = 32'(cfg_q.thr[1]);
			ble_pkg::REG_THR3:  prdata = 32'(cfg_q.thr[2]);
			ble_pkg::REG_THR4:  prdata = 32'(cfg_q.thr[3]);
			ble_pkg::REG_FO_EN: prdata = 32'(cfg_q.fo_en);
			ble_pkg::REG_FO:    prdata = 32'(cfg_q.fo);
			ble_pkg::REG_CAL:   prdata = 32'(unsigned'(cfg_q.cal));
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/ble_window.sv =====
// Sample correction, sliding window with running sum, and window average.
`timescale 1ns / 1ps
`default_nettype none

module ble_window #(
	parameter int WINDOW = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ble_pkg::cfg_t                 cfg,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [ble_pkg::RAW_W-1:0]     raw,
	output      logic                          avg_valid,
	input  wire logic                          avg_stall,
	output      logic [ble_pkg::SAMPLE_W-1:0]  avg
);

	localparam int IDX_W   = $clog2(WINDOW);
	localparam int SUM_W   = ble_pkg::SAMPLE_W + IDX_W;
	// reciprocal multiply: exact floor(sum / WINDOW) for every sum below 2**SUM_W
	localparam int DIV_SH  = SUM_W + IDX_W;
	localparam int MUL_W   = SUM_W + 1;
	localparam longint DIV_MUL_L =
		((longint'(1) << DIV_SH) + longint'(WINDOW) - 1) / longint'(WINDOW);
	localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	// stage valids and readiness
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [ble_pkg::RAW_W-1:0]    raw_s1;
	logic [ble_pkg::SAMPLE_W-1:0] samp_s2;
	logic [SUM_W-1:0]             sum_s3;
	logic [ble_pkg::SAMPLE_W-1:0] avg_s4;

	// window state
	logic [ble_pkg::SAMPLE_W-1:0] win_q [WINDOW];
	logic [IDX_W-1:0]             wi_q;
	logic                         primed_q;
	logic [SUM_W-1:0]             sum_q;

	logic                         win_fire;
	logic [SUM_W-1:0]             sum_next;
	logic [ble_pkg::SAMPLE_W-1:0] samp_next;
	logic [ble_pkg::FO_W-1:0]     fo_add;
	logic signed [ble_pkg::CAL_W:0] cal_adj;
	logic signed [ble_pkg::CAL_W:0] cal_half;
	logic signed [14:0]           corr;
	logic [SUM_W+MUL_W-1:0]       prod;

	assign rdy_s4   = !v_s4 || !avg_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign avg_valid = v_s4;
	assign avg       = avg_s4;
	assign win_fire  = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// correction: fixed offset, half calibration offset toward zero, clamp
	always_comb begin
		fo_add   = cfg.fo_en ? cfg.fo : '0;
		cal_adj  = (ble_pkg::CAL_W+1)'(cfg.cal) + signed'({{ble_pkg::CAL_W{1'b0}}, cfg.cal[ble_pkg::CAL_W-1]});
		cal_half = cal_adj >>> 1;
		corr     = signed'(15'(raw_s1)) + signed'(15'(fo_add)) + 15'(cal_half);
		if (corr < 0) begin
			samp_next = '0;
		end else if (corr > signed'(15'(ble_pkg::SAMPLE_MAX))) begin
			samp_next = ble_pkg::SAMPLE_MAX;
		end else begin
			samp_next = corr[ble_pkg::SAMPLE_W-1:0];
		end
	end

	// running sum: first beat fills the whole window
	always_comb begin
		if (!primed_q) begin
			sum_next = SUM_W'(samp_s2) * SUM_W'(WINDOW);
		end else begin
			sum_next = sum_q - SUM_W'(win_q[wi_q]) + SUM_W'(samp_s2);
		end
	end

	assign prod = (SUM_W+MUL_W)'(sum_s3) * (SUM_W+MUL_W)'(DIV_MUL);

	// window control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			wi_q     <= '0;
		end else if (win_fire) begin
			primed_q <= 1'b1;
			if (primed_q) begin
				wi_q <= (wi_q == IDX_LAST) ? '0 : wi_q + 1'b1;
			end
		end
	end

	// window contents and sum
	always_ff @(posedge clk) begin
		if (win_fire) begin
			sum_q <= sum_next;
			for (int i = 0; i < WINDOW; i++) begin
				if (!primed_q || wi_q == IDX_W'(i)) begin
					win_q[i] <= samp_s2;
				end
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s1) raw_s1  <= raw;
		if (rdy_s2) samp_s2 <= samp_next;
		if (rdy_s3) sum_s3  <= sum_next;
		if (rdy_s4) avg_s4  <= ble_pkg::SAMPLE_W'(prod >> DIV_SH);
	end

endmodule

`default_nettype wire

// ===== hdl/ble_level.sv =====
// Level quantizer, odd-poll debounce and empty counter with output register.
`timescale 1ns / 1ps
`default_nettype none

module ble_level (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ble_pkg::cfg_t                 cfg,
	input  wire logic                          avg_valid,
	output      logic                          avg_stall,
	input  wire logic [ble_pkg::SAMPLE_W-1:0]  avg,
	output      logic                          res_valid,
	input  wire logic                          res_stall,
	output      logic [ble_pkg::LEVEL_W-1:0]   level,
	output      logic                          flag,
	output      logic [ble_pkg::SAMPLE_W-1:0]  res_avg
);

	logic                         v_s5;
	logic [ble_pkg::LEVEL_W-1:0]  level_s5;
	logic                         flag_s5;
	logic [ble_pkg::SAMPLE_W-1:0] avg_s5;

	logic [ble_pkg::LEVEL_W-1:0]  prev_q;
	logic [ble_pkg::LEVEL_W-1:0]  rep_q;
	logic                         parity_q;
	logic [ble_pkg::EMPTY_W-1:0]  empty_q;

	logic                         fire;
	logic [ble_pkg::LEVEL_W-1:0]  lvl;
	logic [ble_pkg::LEVEL_W-1:0]  rep_next;
	logic [ble_pkg::EMPTY_W-1:0]  empty_next;
	logic                         flag_next;
	logic                         count_on;

	assign avg_stall = v_s5 && res_stall;
	assign fire      = avg_valid && !avg_stall;
	assign res_valid = v_s5;
	assign level     = level_s5;
	assign flag      = flag_s5;
	assign res_avg   = avg_s5;

	// quantize: highest threshold exceeded wins
	always_comb begin
		lvl = '0;
		for (int i = 0; i < ble_pkg::LVL_USED; i++) begin
			if (avg > cfg.thr[i]) begin
				lvl = ble_pkg::LEVEL_W'(i + 1);
			end
		end
	end

	// debounce and empty count
	always_comb begin
		rep_next = (!parity_q || lvl == prev_q) ? lvl : rep_q;
		count_on = (empty_q != '0) || (rep_next == '0);
		empty_next = empty_q;
		flag_next  = 1'b0;
		if (count_on) begin
			if (empty_q < ble_pkg::EMPTY_SAT) begin
				empty_next = empty_q + 1'b1;
			end
			flag_next = (empty_q == ble_pkg::EMPTY_MARK - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5     <= 1'b0;
			prev_q   <= '0;
			rep_q    <= '0;
			parity_q <= 1'b0;
			empty_q  <= '0;
		end else begin
			if (!avg_stall) v_s5 <= avg_valid;
			if (fire) begin
				prev_q   <= lvl;
				rep_q    <= rep_next;
				parity_q <= !parity_q;
				empty_q  <= empty_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			level_s5 <= rep_next;
			flag_s5  <= flag_next;
			avg_s5   <= avg;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/battery_level_estimator.sv =====
// Top level of the battery level estimator.
//
//  channel   direction  handshake                   payload
//  sample    in         sample_valid/sample_stall   raw_sample[11:0]
//  result    out        result_valid/result_stall   battery_level[2:0], empty_flag, average[12:0]
//  config    in         APB psel/penable/pwrite     paddr[4:0], pwdata/prdata[31:0]
//
// One sample beat per cycle sustained while no result stall backs up the pipeline; a result
// passes the input, correction, window sum, reciprocal multiply and level registers in
// that order before it is on the output.
// The window sum is kept running, so each beat costs one add/subtract and one multiply.
// Reset clears the window control, debounce and empty counter; registers take defaults.
// A result stall holds the output register; upstream stages keep filling until full.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_estimator #(
	parameter int WINDOW = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	input  wire logic        sample_valid,
	output      logic        sample_stall,
	input  wire logic [11:0] raw_sample,
	output      logic        result_valid,
	input  wire logic        result_stall,
	output      logic [2:0]  battery_level,
	output      logic        empty_flag,
	output      logic [12:0] average
);

	ble_pkg::cfg_t                cfg;
	logic                         avg_valid;
	logic                         avg_stall;
	logic [ble_pkg::SAMPLE_W-1:0] avg;

	ble_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ble_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sample_valid),
		.in_stall  (sample_stall),
		.raw       (raw_sample),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.avg       (avg)
	);

	ble_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.avg       (avg),
		.res_valid (result_valid),
		.res_stall (result_stall),
		.level     (battery_level),
		.flag      (empty_flag),
		.res_avg   (average)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the battery level estimator: directed and random polls.
`timescale 1ns / 1ps

module testbench;

	localparam int WIN         = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [ble_pkg::LEVEL_W-1:0]  level;
		logic                         flag;
		logic [ble_pkg::SAMPLE_W-1:0] avg;
	} level_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic [ble_pkg::RAW_W-1:0]    raw_sample = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [ble_pkg::LEVEL_W-1:0]  battery_level;
	logic               empty_flag;
	logic [ble_pkg::SAMPLE_W-1:0] average;

	// configuration copy kept by the predictor
	logic [ble_pkg::THR_W-1:0] thr_cfg [ble_pkg::NUM_THR] = '{ble_pkg::THR1_RST,
			ble_pkg::THR2_RST, ble_pkg::THR3_RST, ble_pkg::THR4_RST};
	logic                      fo_en_cfg = 1'b1;
	logic [ble_pkg::FO_W-1:0]  fo_cfg = ble_pkg::FO_RST;
	int                        cal_cfg = 0;

	// estimator state kept by the predictor
	logic [ble_pkg::SAMPLE_W-1:0] window_model [WIN];
	int                           window_pos = 0;
	bit                           window_filled = 1'b0;
	logic [ble_pkg::LEVEL_W-1:0]  last_level = '0;
	logic [ble_pkg::LEVEL_W-1:0]  shown_level = '0;
	bit                           odd_poll = 1'b0;
	logic [ble_pkg::EMPTY_W-1:0]  empty_count = '0;

	level_result_t expected_levels [$];
	int            error_count = 0;
	int            results_seen = 0;
	int            cycle_count = 0;

	// sender burst control and receiver hold-off requests
	int  burst_left = 0;
	bit  gaps_off = 1'b0;
	int  hold_asked = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	logic [7:0] stall_phase = '0;

	battery_level_estimator #(.WINDOW(WIN)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.raw_sample(raw_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.battery_level(battery_level),
		.empty_flag(empty_flag),
		.average(average)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
		error_count++;
	endtask

	// highest level whose threshold the average exceeds
	function automatic logic [ble_pkg::LEVEL_W-1:0] quantize_average(
			input logic [ble_pkg::SAMPLE_W-1:0] avg);
		for (int i = ble_pkg::LVL_USED; i > 0; i--) begin
			if (avg > thr_cfg[i-1])
				return ble_pkg::LEVEL_W'(i);
		end
		return '0;
	endfunction

	// one poll: correct, window, quantize, debounce, empty counter
	function automatic void predict_level(input logic [ble_pkg::RAW_W-1:0] raw);
		int                          corrected;
		int                          sum;
		logic [ble_pkg::LEVEL_W-1:0] lvl;
		level_result_t               r;
		corrected = raw;
		if (fo_en_cfg)
			corrected += fo_cfg;
		corrected += cal_cfg / 2;
		if (corrected < 0)
			corrected = 0;
		if (corrected > int'(ble_pkg::SAMPLE_MAX))
			corrected = int'(ble_pkg::SAMPLE_MAX);
		r.flag = 1'b0;
		if (!window_filled) begin
			for (int i = 0; i < WIN; i++)
				window_model[i] = ble_pkg::SAMPLE_W'(corrected);
			r.avg = ble_pkg::SAMPLE_W'(corrected);
			lvl = quantize_average(r.avg);
			shown_level = lvl;
			window_filled = 1'b1;
		end else begin
			window_model[window_pos] = ble_pkg::SAMPLE_W'(corrected);
			window_pos = (window_pos + 1) % WIN;
			sum = 0;
			for (int i = 0; i < WIN; i++)
				sum += window_model[i];
			r.avg = ble_pkg::SAMPLE_W'(sum / WIN);
			lvl = quantize_average(r.avg);
			if (lvl == last_level)
				shown_level = lvl;
		end
		last_level = lvl;
		if (!odd_poll)
			shown_level = lvl;
		odd_poll = ~odd_poll;
		if (empty_count != 0 || shown_level == 0) begin
			if (empty_count < ble_pkg::EMPTY_SAT)
				empty_count++;
			if (empty_count == ble_pkg::EMPTY_MARK)
				r.flag = 1'b1;
		end
		r.level = shown_level;
		expected_levels.push_back(r);
	endfunction

	// predict on every accepted sample beat, check every accepted result beat
	always @(posedge clk) begin : beat_monitor
		level_result_t want;
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				predict_level(raw_sample);
			if (result_valid && !result_stall) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("unexpected result, level", battery_level, 0);
				end else begin
					want = expected_levels.pop_front();
					if (battery_level !== want.level)
						report_mismatch("battery_level", battery_level, want.level);
					if (empty_flag !== want.flag)
						report_mismatch("empty_flag", empty_flag, want.flag);
					if (average !== want.avg)
						report_mismatch("average", average, want.avg);
				end
				results_seen++;
			end
		end
	end

	// receiver: long hold-off on request, otherwise a cycling stall pattern
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			stall_phase <= stall_phase + 1;
			case (stall_phase[7:6])
				2'd0: result_stall <= 1'b0;
				2'd1: result_stall <= ($urandom_range(0, 3) == 0);
				2'd2: result_stall <= ($urandom_range(0, 1) == 0);
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// APB write: setup then access, register taken when pready is high, then the bus goes idle
	task automatic write_reg(input ble_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ble_pkg::REG_THR1, ble_pkg::REG_THR2, ble_pkg::REG_THR3, ble_pkg::REG_THR4:
				thr_cfg[idx[1:0]] = value[ble_pkg::THR_W-1:0];
			ble_pkg::REG_FO_EN: fo_en_cfg = value[0];
			ble_pkg::REG_FO: fo_cfg = value[ble_pkg::FO_W-1:0];
			ble_pkg::REG_CAL: cal_cfg = $signed(value[ble_pkg::CAL_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_config(input int t1, input int t2, input int t3, input int t4,
			input int en, input int fo, input int cal);
		write_reg(ble_pkg::REG_THR1, t1);
		write_reg(ble_pkg::REG_THR2, t2);
		write_reg(ble_pkg::REG_THR3, t3);
		write_reg(ble_pkg::REG_THR4, t4);
		write_reg(ble_pkg::REG_FO_EN, en);
		write_reg(ble_pkg::REG_FO, fo);
		write_reg(ble_pkg::REG_CAL, cal & 32'h7FF);
	endtask

	// one sample beat; valid stays high into the next beat unless a gap follows
	task automatic send_beat(input logic [ble_pkg::RAW_W-1:0] raw);
		int gap;
		sample_valid <= 1'b1;
		raw_sample <= raw;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (!gaps_off) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					sample_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	// stop sending and wait until every result is back, plus pipeline slack
	task automatic drain_results;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// first poll fill, swing to empty, values right at the default thresholds
	task automatic test_directed_polls;
		int polls [24] = '{4095, 0, 0, 0, 0, 0, 0, 0, 0, 637, 638, 638, 667, 668, 668,
				676, 677, 684, 685, 685, 2730, 1365, 4095, 0};
		foreach (polls[i])
			send_beat(ble_pkg::RAW_W'(polls[i]));
		drain_results;
	endtask

	// register extremes, clamping at zero, calibration rounding toward zero
	task automatic test_config_extremes;
		apply_config(0, 0, 0, 0, 0, 255, 1023);
		send_beat(12'd0);
		send_beat(12'd4095);
		send_beat(12'd1);
		drain_results;
		apply_config(8191, 8191, 8191, 8191, 1, 255, -1024);
		send_beat(12'd0);
		send_beat(12'd4095);
		send_beat(12'd256);
		drain_results;
		apply_config(1, 2, 3, 4, 0, 0, -1);
		send_beat(12'd0);
		send_beat(12'd1);
		send_beat(12'd5);
		drain_results;
		apply_config(700, 600, 500, 400, 1, 0, -3);
		send_beat(12'd0);
		send_beat(12'd4095);
		send_beat(12'd550);
		drain_results;
		apply_config(20, 40, 60, 80, 0, 128, 1);
		send_beat(12'd30);
		send_beat(12'd60);
		drain_results;
	endtask

	// slowly drifting battery voltage around random thresholds, some noise
	task automatic test_random_phases;
		int base, en, fo, cal, volt, step, raw;
		int t [4];
		for (int ph = 0; ph < 6; ph++) begin
			en = $urandom_range(0, 1);
			fo = $urandom_range(0, 255);
			cal = int'($urandom_range(0, 2047)) - 1024;
			base = $urandom_range(200, 4000);
			if (ph % 3 == 2) begin
				foreach (t[i])
					t[i] = $urandom_range(0, 8191);
			end else begin
				t[0] = base;
				for (int i = 1; i < 4; i++)
					t[i] = t[i-1] + int'($urandom_range(0, 60));
			end
			apply_config(t[0], t[1], t[2], t[3], en, fo, cal);
			volt = base - en * fo - cal / 2;
			repeat (80) begin
				if ($urandom_range(0, 9) == 0) begin
					raw = $urandom_range(0, 4095);
				end else begin
					step = $urandom_range(0, 80);
					volt = volt + step - 40;
					if (volt < 0)
						volt = 0;
					if (volt > 4095)
						volt = 4095;
					raw = volt;
				end
				send_beat(ble_pkg::RAW_W'(raw));
			end
			drain_results;
		end
	endtask

	// receiver holds off while samples keep coming, so the input stalls
	task automatic test_backpressure;
		gaps_off = 1'b1;
		hold_asked <= hold_asked + 1;
		repeat (40) send_beat(ble_pkg::RAW_W'($urandom_range(0, 4095)));
		gaps_off = 1'b0;
		drain_results;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_polls;
		test_config_extremes;
		test_random_phases;
		test_backpressure;
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ble_pkg.sv
hdl/ble_cfg.sv
hdl/ble_window.sv
hdl/ble_level.sv
hdl/battery_level_estimator.sv
verif/testbench.sv
